// ===== rtl/core/cpf_pkg.sv =====
// Shared types, constants and the CRC step function for the command packet framer.
package cpf_pkg;

  localparam logic [7:0]  WORD_ADDRESS = 8'h03;
  localparam logic [7:0]  COUNT_EXTRA  = 8'd7;
  localparam logic [7:0]  MAX_PAYLOAD  = 8'd248;
  localparam logic [15:0] CRC_POLY     = 16'h8005;

  // Status codes carried on the result tuser
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_STRAY_DATA = 2'd1;
  localparam logic [1:0] STATUS_DUP_START  = 2'd2;

  // Input action codes
  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_DATA  = 1'b1;

  // Header step numbers (CRC bytes follow at CRC_LO/CRC_HI)
  localparam logic [2:0] HDR_ADDR  = 3'd0;
  localparam logic [2:0] HDR_COUNT = 3'd1;
  localparam logic [2:0] HDR_OPC   = 3'd2;
  localparam logic [2:0] HDR_P1    = 3'd3;
  localparam logic [2:0] HDR_P2_LO = 3'd4;
  localparam logic [2:0] HDR_P2_HI = 3'd5;
  localparam logic [2:0] HDR_CRC_LO = 3'd6;
  localparam logic [2:0] HDR_CRC_HI = 3'd7;
  localparam logic [2:0] DAT_BYTE   = 3'd0;
  localparam logic [2:0] DAT_CRC_LO = 3'd1;
  localparam logic [2:0] DAT_CRC_HI = 3'd2;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_DATA,
    CMD_BAD_DATA,
    CMD_BAD_START
  } cmd_kind_t;

  // One classified command handed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  first_byte; // opcode on a header, payload byte on data
    logic [7:0]  param_one;
    logic [15:0] param_two;
    logic [7:0]  count;
    logic        tail;       // append the CRC after this command
  } cmd_t;

  // Feed one byte, LSB first, into a left-shifting CRC register
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = data[i] ^ crc[15];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

// ===== rtl/core/cpf_front.sv =====
// Front end: accepts input words, tracks the open frame and classifies each word.
module cpf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [7:0]          opcode,
  input  logic [7:0]          param_one,
  input  logic [15:0]         param_two,
  input  logic [7:0]          payload_length,
  input  logic [7:0]          payload_byte,
  input  logic                queue_full,
  output logic                push,
  output cpf_pkg::cmd_t       cmd
);

  logic       open_r, open_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] len_sat;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;
  assign len_sat  = (payload_length > cpf_pkg::MAX_PAYLOAD) ? cpf_pkg::MAX_PAYLOAD
                                                            : payload_length;

  always_comb begin
    open_nxt       = open_r;
    remain_nxt     = remain_r;
    cmd.first_byte = opcode;
    cmd.param_one  = param_one;
    cmd.param_two  = param_two;
    cmd.count      = 8'(len_sat + cpf_pkg::COUNT_EXTRA);
    cmd.tail       = 1'b0;
    cmd.kind       = cpf_pkg::CMD_HEADER;
    if (action == cpf_pkg::ACTION_START) begin
      if (open_r) begin
        cmd.kind = cpf_pkg::CMD_BAD_START;
      end else begin
        cmd.tail = (len_sat == 8'd0);
        if (push) begin
          open_nxt   = (len_sat != 8'd0);
          remain_nxt = len_sat;
        end
      end
    end else begin
      cmd.first_byte = payload_byte;
      if (!open_r) begin
        cmd.kind = cpf_pkg::CMD_BAD_DATA;
      end else begin
        cmd.kind = cpf_pkg::CMD_DATA;
        cmd.tail = (remain_r == 8'd1);
        if (push) begin
          remain_nxt = 8'(remain_r - 8'd1);
          open_nxt   = (remain_r != 8'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      remain_r <= 8'd0;
    end else begin
      open_r   <= open_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

// ===== rtl/core/cpf_queue.sv =====
// Short command queue between front and back ends.
module cpf_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cpf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output cpf_pkg::cmd_t head_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cpf_pkg::cmd_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (!push && do_pop) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/cpf_back.sv =====
// Back end: serialises each command into packet bytes, runs the CRC, holds the output register.
module cpf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  cpf_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic [1:0]    out_status
);

  logic [2:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        slot_free, fire, final_step;

  assign slot_free = !valid_r || out_ready;
  assign fire      = head_valid && slot_free;
  assign pop       = fire && final_step;

  always_comb begin
    final_step = 1'b1;
    byte_nxt   = 8'd0;
    last_nxt   = 1'b0;
    status_nxt = cpf_pkg::STATUS_OK;
    crc_nxt    = crc_r;
    case (head_cmd.kind)
      cpf_pkg::CMD_HEADER: begin
        final_step = (step_r == (head_cmd.tail ? cpf_pkg::HDR_CRC_HI : cpf_pkg::HDR_P2_HI));
        case (step_r)
          cpf_pkg::HDR_ADDR:   byte_nxt = cpf_pkg::WORD_ADDRESS;
          cpf_pkg::HDR_COUNT:  byte_nxt = head_cmd.count;
          cpf_pkg::HDR_OPC:    byte_nxt = head_cmd.first_byte;
          cpf_pkg::HDR_P1:     byte_nxt = head_cmd.param_one;
          cpf_pkg::HDR_P2_LO:  byte_nxt = head_cmd.param_two[7:0];
          cpf_pkg::HDR_P2_HI:  byte_nxt = head_cmd.param_two[15:8];
          cpf_pkg::HDR_CRC_LO: byte_nxt = crc_r[7:0];
          default:             byte_nxt = crc_r[15:8];
        endcase
        last_nxt = (step_r == cpf_pkg::HDR_CRC_HI);
        // word address is outside the CRC; count to param_two high are inside
        if (step_r == cpf_pkg::HDR_ADDR) begin
          crc_nxt = 16'd0;
        end else if (step_r <= cpf_pkg::HDR_P2_HI) begin
          crc_nxt = cpf_pkg::crc_feed(crc_r, byte_nxt);
        end
      end
      cpf_pkg::CMD_DATA: begin
        final_step = (step_r == (head_cmd.tail ? cpf_pkg::DAT_CRC_HI : cpf_pkg::DAT_BYTE));
        case (step_r)
          cpf_pkg::DAT_BYTE:   byte_nxt = head_cmd.first_byte;
          cpf_pkg::DAT_CRC_LO: byte_nxt = crc_r[7:0];
          default:             byte_nxt = crc_r[15:8];
        endcase
        last_nxt = (step_r == cpf_pkg::DAT_CRC_HI);
        if (step_r == cpf_pkg::DAT_BYTE) begin
          crc_nxt = cpf_pkg::crc_feed(crc_r, head_cmd.first_byte);
        end
      end
      cpf_pkg::CMD_BAD_DATA: begin
        status_nxt = cpf_pkg::STATUS_STRAY_DATA;
      end
      default: begin
        status_nxt = cpf_pkg::STATUS_DUP_START;
      end
    endcase
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = head_valid;
    end
    if (fire) begin
      step_nxt = final_step ? 3'd0 : 3'(step_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 3'd0;
      valid_r <= 1'b0;
      crc_r   <= 16'd0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
      if (fire) begin
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r   <= byte_nxt;
      last_r   <= last_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_status = status_r;

endmodule

// ===== rtl/core/command_packet_framer_crc16_core.sv =====
// Top level of the framed command packet builder with CRC-16.
// Usage:
//  - Input channel (in_*): one word per handshake. tuser = 0 opens a frame
//    with opcode, param_one, param_two and payload_length; tuser = 1 carries
//    one payload byte. Payload lengths above 248 are saturated to 248.
//  - Result channel (out_*): one packet byte per word. A start yields
//    address 0x03, count, opcode, param_one, param_two low/high; each data
//    word yields its byte; after the last payload byte the CRC-16 (poly
//    0x8005, init 0, LSB-first feed) follows low byte first with tlast on
//    the high byte. Stray data or a start inside an open frame gives one
//    word with tuser = 1 or 2 and data 0; frame state is left alone.
//  - The first result byte passes through the command queue and then the
//    output register. Throughput: one result byte per cycle while
//    out_tready is high, set by the back-end serialiser; a data word gives
//    one byte (three on the last), a start six (eight with empty payload).
//  - A QUEUE_DEPTH-entry command queue decouples the front end from the
//    serialiser, so in_tready stays high until the queue fills while out is
//    stalled. Reset (rst_n low, synchronous) closes any frame and empties
//    the queue and output register.
module command_packet_framer_crc16_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[7:0], param_one[15:8], param_two[31:16], payload_length[39:32],
  // payload_byte[47:40]
  input  logic [47:0] in_tdata,
  // action[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // status[1:0]
  output logic [1:0]  out_tuser
);

  cpf_pkg::cmd_t front_cmd;
  cpf_pkg::cmd_t head_cmd;
  logic          push, queue_full, head_valid, pop;

  cpf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .action         (in_tuser),
    .opcode         (in_tdata[7:0]),
    .param_one      (in_tdata[15:8]),
    .param_two      (in_tdata[31:16]),
    .payload_length (in_tdata[39:32]),
    .payload_byte   (in_tdata[47:40]),
    .queue_full     (queue_full),
    .push           (push),
    .cmd            (front_cmd)
  );

  cpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // serialiser and output register
  cpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

endmodule
